@@ rtl/gas_pkg.sv @@
// Shared constants, types and helper functions of the grid A* search block.
package gas_pkg;

	localparam int MAX_WIDTH      = 32;
	localparam int MAX_HEIGHT     = 32;
	localparam int OPEN_DEPTH     = 4096;
	localparam int HEUR_FRAC_BITS = 8;

	localparam int CELLS    = MAX_WIDTH * MAX_HEIGHT;
	localparam int CELL_W   = $clog2(CELLS);
	localparam int COORD_W  = 5;
	localparam int DIM_W    = 6;
	localparam int COST_W   = 11;
	localparam int LEN_W    = $clog2(CELLS + 1);
	localparam int CNT_W    = $clog2(OPEN_DEPTH + 1);
	localparam int HIDX_W   = $clog2(OPEN_DEPTH);
	localparam int CH_W     = HIDX_W + 2;
	localparam int RAD_W    = 2 * COORD_W + 1 + 2 * HEUR_FRAC_BITS;
	localparam int ROOT_W   = (RAD_W + 1) / 2;
	localparam int F_W      = COST_W + 1 + HEUR_FRAC_BITS + 1;
	localparam int SEQ_W    = 16;

	localparam logic [COST_W-1:0] COST_MAX = '1;

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_SEARCH = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;

	localparam logic [1:0] ST_FOUND    = 2'd0;
	localparam logic [1:0] ST_NOPATH   = 2'd1;
	localparam logic [1:0] ST_BADXY    = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_PATH   = 1'b1;

	localparam logic [1:0] DIR_XP = 2'd0;
	localparam logic [1:0] DIR_XN = 2'd1;
	localparam logic [1:0] DIR_YP = 2'd2;
	localparam logic [1:0] DIR_YN = 2'd3;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [1:0]  action;
		logic [9:0]  cell_index;
		logic        cell_blocked;
		logic [4:0]  start_x;
		logic [4:0]  start_y;
		logic [4:0]  goal_x;
		logic [4:0]  goal_y;
	} cmd_t;

	typedef struct packed {
		logic        result_kind;
		logic [1:0]  status;
		logic [10:0] path_length;
		logic [9:0]  path_cell;
		logic        last;
	} res_t;

	typedef struct packed {
		logic valid;
		res_t beat;
	} eng_res_t;

	typedef struct packed {
		logic [F_W-1:0]     f;
		logic [SEQ_W-1:0]   seq;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} heap_entry_t;

	function automatic logic [CELL_W-1:0] cell_idx(input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y, input logic [DIM_W-1:0] w);
		logic [COORD_W+DIM_W-1:0] prod;
		prod = (COORD_W + DIM_W)'(y) * (COORD_W + DIM_W)'(w);
		return CELL_W'(prod + (COORD_W + DIM_W)'(x));
	endfunction

	function automatic logic entry_less(input heap_entry_t a, input heap_entry_t b);
		if (a.f != b.f)
			return a.f < b.f;
		return a.seq < b.seq;
	endfunction

	function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

endpackage

@@ rtl/gas_ram.sv @@
// Generic simple dual-port RAM with registered read.
module gas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

@@ rtl/gas_isqrt.sv @@
// Iterative heuristic unit: floor of scaled Euclidean distance, two radicand bits a cycle.
module gas_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [gas_pkg::COORD_W-1:0] dx,
	input  logic [gas_pkg::COORD_W-1:0] dy,
	output logic                        done,
	output logic [gas_pkg::ROOT_W-1:0]  root
);
	import gas_pkg::*;

	localparam int PAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;
	localparam int STP_W = $clog2(ROOT_W + 1);

	logic [PAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [STP_W-1:0]  step_q;
	logic              run_q;
	logic              done_q;

	logic [2*COORD_W:0] dist2;
	logic [REM_W+1:0]   shifted;
	logic [REM_W+1:0]   trial;

	assign dist2   = (2*COORD_W+1)'(dx) * (2*COORD_W+1)'(dx) +
	                 (2*COORD_W+1)'(dy) * (2*COORD_W+1)'(dy);
	assign shifted = {rem_q, rad_q[PAD_W-1 -: 2]};
	assign trial   = (REM_W+2)'({root_q, 2'b01});
	assign done    = done_q;
	assign root    = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= STP_W'(ROOT_W);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= PAD_W'(dist2) << (2 * HEUR_FRAC_BITS);
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q <= rad_q << 2;
			if (shifted >= trial) begin
				rem_q  <= REM_W'(shifted - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= REM_W'(shifted);
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end
endmodule

@@ rtl/gas_engine.sv @@
// Search engine: map, cost, parent, open heap and path memories with their sequencer.
module gas_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [gas_pkg::DIM_W-1:0] grid_w,
	input  logic [gas_pkg::DIM_W-1:0] grid_h,
	input  logic                      cmd_valid,
	input  gas_pkg::cmd_t             cmd,
	output logic                      cmd_ready,
	output gas_pkg::eng_res_t         eres,
	input  logic                      res_take
);
	import gas_pkg::*;

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_CLR     = 5'd1;
	localparam logic [4:0] S_INIT    = 5'd2;
	localparam logic [4:0] S_HWAIT   = 5'd3;
	localparam logic [4:0] S_PU_RD   = 5'd4;
	localparam logic [4:0] S_PU_CMP  = 5'd5;
	localparam logic [4:0] S_POP     = 5'd6;
	localparam logic [4:0] S_PO_TOP  = 5'd7;
	localparam logic [4:0] S_PO_LAST = 5'd8;
	localparam logic [4:0] S_SD_RL   = 5'd9;
	localparam logic [4:0] S_SD_RR   = 5'd10;
	localparam logic [4:0] S_SD_CMP  = 5'd11;
	localparam logic [4:0] S_EXP     = 5'd12;
	localparam logic [4:0] S_EXP_G   = 5'd13;
	localparam logic [4:0] S_NB      = 5'd14;
	localparam logic [4:0] S_NB_CHK  = 5'd15;
	localparam logic [4:0] S_NB_NEXT = 5'd16;
	localparam logic [4:0] S_PA_CHK  = 5'd17;
	localparam logic [4:0] S_PA_STEP = 5'd18;
	localparam logic [4:0] S_PB_WR   = 5'd19;
	localparam logic [4:0] S_PB_STEP = 5'd20;
	localparam logic [4:0] S_EMIT_SR = 5'd21;
	localparam logic [4:0] S_EMIT_RD = 5'd22;
	localparam logic [4:0] S_MCLR    = 5'd23;

	logic [4:0]         state_q;
	logic [COORD_W-1:0] sx_q, sy_q, gx_q, gy_q;
	logic [CELL_W-1:0]  clr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SEQ_W-1:0]   seq_q;
	logic [HIDX_W-1:0]  hole_q;
	heap_entry_t        x_q, lc_q;
	logic [COORD_W-1:0] cx_q, cy_q, nx_q, ny_q, px_q, py_q;
	logic [COST_W-1:0]  g_q;
	logic [COST_W:0]    ng_q;
	logic [1:0]         dir_q;
	logic               from_start_q;
	logic [LEN_W-1:0]   len_q, k_q, slen_q, rp_q;
	logic [1:0]         stat_q;

	// memory ports
	logic              map_we, map_re, map_rdata, map_wdata;
	logic [CELL_W-1:0] map_waddr, map_raddr;
	logic              cost_we, cost_re;
	logic [CELL_W-1:0] cost_waddr, cost_raddr;
	logic [COST_W-1:0] cost_wdata, cost_rdata;
	logic              par_we, par_re;
	logic [CELL_W-1:0] par_waddr, par_raddr;
	logic [1:0]        par_rdata;
	logic              h_we, h_re;
	logic [HIDX_W-1:0] h_waddr, h_raddr;
	heap_entry_t       h_wdata, h_rdata;
	logic              pb_we, pb_re;
	logic [CELL_W-1:0] pb_waddr;
	logic [CELL_W-1:0] pb_rdata;

	logic               isq_start, isq_done;
	logic [COORD_W-1:0] isq_dx, isq_dy;
	logic [ROOT_W-1:0]  isq_root;

	logic               cmd_acc, bad_xy;
	logic [CELL_W-1:0]  cur_idx, nb_idx, nq_idx, p_idx, s_idx;
	logic [DIM_W-1:0]   nbx, nby;
	logic               nb_in, upd, at_start, at_goal, walk_stop;
	logic [COST_W:0]    ng;
	logic [HIDX_W-1:0]  hp;
	logic [CH_W-1:0]    l_idx, r_idx, cnt_ext;
	logic               l_ok, r_ok, sel_l, sel_r;
	heap_entry_t        best0, best;
	logic [HIDX_W-1:0]  m_idx;
	logic [F_W-1:0]     f_new;
	logic [COORD_W-1:0] bx, by;

	gas_ram #(.WIDTH(1), .DEPTH(CELLS)) u_map (
		.clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
		.re(map_re), .raddr(map_raddr), .rdata(map_rdata));

	gas_ram #(.WIDTH(COST_W), .DEPTH(CELLS)) u_cost (
		.clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
		.re(cost_re), .raddr(cost_raddr), .rdata(cost_rdata));

	gas_ram #(.WIDTH(2), .DEPTH(CELLS)) u_par (
		.clk(clk), .we(par_we), .waddr(par_waddr), .wdata(dir_q),
		.re(par_re), .raddr(par_raddr), .rdata(par_rdata));

	gas_ram #(.WIDTH($bits(heap_entry_t)), .DEPTH(OPEN_DEPTH)) u_heap (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.re(h_re), .raddr(h_raddr), .rdata(h_rdata));

	gas_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_path (
		.clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(p_idx),
		.re(pb_re), .raddr(rp_q[CELL_W-1:0]), .rdata(pb_rdata));

	gas_isqrt u_heur (
		.clk(clk), .arst_n(arst_n), .start(isq_start), .dx(isq_dx), .dy(isq_dy),
		.done(isq_done), .root(isq_root));

	assign cmd_ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd_valid && cmd_ready;
	assign bad_xy    = ({1'b0, cmd.start_x} >= grid_w) || ({1'b0, cmd.start_y} >= grid_h) ||
	                   ({1'b0, cmd.goal_x} >= grid_w) || ({1'b0, cmd.goal_y} >= grid_h);

	assign cur_idx = cell_idx(cx_q, cy_q, grid_w);
	assign nq_idx  = cell_idx(nx_q, ny_q, grid_w);
	assign p_idx   = cell_idx(px_q, py_q, grid_w);
	assign s_idx   = cell_idx(sx_q, sy_q, grid_w);
	assign nb_idx  = cell_idx(nbx[COORD_W-1:0], nby[COORD_W-1:0], grid_w);

	always_comb begin
		nbx = {1'b0, cx_q};
		nby = {1'b0, cy_q};
		case (dir_q)
			DIR_XP: nbx = {1'b0, cx_q} + 1'b1;
			DIR_XN: nbx = {1'b0, cx_q} - 1'b1;
			DIR_YP: nby = {1'b0, cy_q} + 1'b1;
			DIR_YN: nby = {1'b0, cy_q} - 1'b1;
			default: ;
		endcase
	end
	assign nb_in = (nbx < grid_w) && (nby < grid_h);

	// step back toward the start along the stored direction
	always_comb begin
		bx = px_q;
		by = py_q;
		case (par_rdata)
			DIR_XP: bx = px_q - 1'b1;
			DIR_XN: bx = px_q + 1'b1;
			DIR_YP: by = py_q - 1'b1;
			DIR_YN: by = py_q + 1'b1;
			default: ;
		endcase
	end

	assign ng        = {1'b0, g_q} + 1'b1;
	assign upd       = !map_rdata && (ng < {1'b0, cost_rdata});
	assign at_start  = (px_q == sx_q) && (py_q == sy_q);
	assign at_goal   = (cx_q == gx_q) && (cy_q == gy_q);
	assign walk_stop = at_start || (len_q >= LEN_W'(CELLS));
	assign f_new     = (F_W'(ng_q) << HEUR_FRAC_BITS) + F_W'(isq_root);

	assign hp      = (hole_q - 1'b1) >> 1;
	assign l_idx   = {1'b0, hole_q, 1'b1};
	assign r_idx   = l_idx + 1'b1;
	assign cnt_ext = CH_W'(cnt_q);
	assign l_ok    = l_idx < cnt_ext;
	assign r_ok    = r_idx < cnt_ext;
	assign sel_l   = entry_less(lc_q, x_q);
	assign best0   = sel_l ? lc_q : x_q;
	assign sel_r   = r_ok && entry_less(h_rdata, best0);
	assign best    = sel_r ? h_rdata : best0;
	assign m_idx   = sel_r ? r_idx[HIDX_W-1:0] : (sel_l ? l_idx[HIDX_W-1:0] : hole_q);

	assign isq_dx = (state_q == S_INIT) ? abs_diff(sx_q, gx_q) : abs_diff(nx_q, gx_q);
	assign isq_dy = (state_q == S_INIT) ? abs_diff(sy_q, gy_q) : abs_diff(ny_q, gy_q);

	always_comb begin
		map_we     = 1'b0;
		map_waddr  = CELL_W'(cmd.cell_index);
		map_wdata  = cmd.cell_blocked;
		map_re     = 1'b0;
		map_raddr  = nb_idx;
		cost_we    = 1'b0;
		cost_re    = 1'b0;
		cost_waddr = nq_idx;
		cost_wdata = ng_q[COST_W-1:0];
		cost_raddr = nb_idx;
		par_we     = 1'b0;
		par_re     = 1'b0;
		par_waddr  = nq_idx;
		par_raddr  = p_idx;
		h_we       = 1'b0;
		h_re       = 1'b0;
		h_waddr    = hole_q;
		h_wdata    = x_q;
		h_raddr    = hp;
		pb_we      = 1'b0;
		pb_re      = 1'b0;
		pb_waddr   = CELL_W'(k_q - 1'b1);
		isq_start  = 1'b0;
		case (state_q)
			S_MCLR: begin
				map_we    = 1'b1;
				map_waddr = clr_q;
				map_wdata = 1'b0;
			end
			S_IDLE: begin
				map_we = cmd_acc && (cmd.action == ACT_LOAD) && (int'(cmd.cell_index) < CELLS);
				pb_re  = cmd_acc && (cmd.action == ACT_READ) && (rp_q < slen_q);
			end
			S_CLR: begin
				cost_we    = 1'b1;
				cost_waddr = clr_q;
				cost_wdata = COST_MAX;
			end
			S_INIT: begin
				cost_we    = 1'b1;
				cost_waddr = s_idx;
				cost_wdata = '0;
				isq_start  = 1'b1;
			end
			S_PU_RD: begin
				if (hole_q == '0)
					h_we = 1'b1;
				else
					h_re = 1'b1;
			end
			S_PU_CMP: begin
				h_we = 1'b1;
				if (entry_less(x_q, h_rdata))
					h_wdata = h_rdata;
			end
			S_POP: begin
				h_re    = (cnt_q != '0);
				h_raddr = '0;
			end
			S_PO_TOP: begin
				h_re    = 1'b1;
				h_raddr = HIDX_W'(cnt_q - 1'b1);
			end
			S_SD_RL: begin
				h_raddr = l_idx[HIDX_W-1:0];
				if (l_ok)
					h_re = 1'b1;
				else
					h_we = 1'b1;
			end
			S_SD_RR: begin
				h_raddr = r_idx[HIDX_W-1:0];
				h_re    = r_ok;
			end
			S_SD_CMP: begin
				h_we    = 1'b1;
				h_wdata = best;
			end
			S_EXP: begin
				cost_re    = !at_goal;
				cost_raddr = cur_idx;
			end
			S_NB: begin
				map_re  = nb_in;
				cost_re = nb_in;
			end
			S_NB_CHK: begin
				cost_we    = upd;
				cost_wdata = ng[COST_W-1:0];
				par_we     = upd;
				isq_start  = upd;
			end
			S_PA_CHK: begin
				par_re = !walk_stop;
			end
			S_PB_WR: begin
				pb_we  = 1'b1;
				par_re = (k_q != LEN_W'(1)) && !at_start;
			end
			default: ;
		endcase
	end

	always_comb begin
		eres.valid = (state_q == S_EMIT_SR) || (state_q == S_EMIT_RD);
		if (state_q == S_EMIT_RD) begin
			eres.beat.result_kind = KIND_PATH;
			eres.beat.status      = ST_FOUND;
			eres.beat.path_cell   = 10'(pb_rdata);
			eres.beat.last        = (rp_q + 1'b1 == slen_q);
		end else begin
			eres.beat.result_kind = KIND_REPORT;
			eres.beat.status      = stat_q;
			eres.beat.path_cell   = '0;
			eres.beat.last        = 1'b0;
		end
		eres.beat.path_length = 11'(slen_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_MCLR;
			clr_q        <= '0;
			slen_q       <= '0;
			rp_q         <= '0;
			cnt_q        <= '0;
			seq_q        <= '0;
			stat_q       <= ST_FOUND;
			from_start_q <= 1'b0;
		end else begin
			case (state_q)
				// open every map cell once after reset
				S_MCLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CELL_W'(CELLS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cmd_acc && cmd.action == ACT_SEARCH) begin
						sx_q   <= cmd.start_x;
						sy_q   <= cmd.start_y;
						gx_q   <= cmd.goal_x;
						gy_q   <= cmd.goal_y;
						slen_q <= '0;
						rp_q   <= '0;
						clr_q  <= '0;
						if (bad_xy) begin
							stat_q  <= ST_BADXY;
							state_q <= S_EMIT_SR;
						end else begin
							state_q <= S_CLR;
						end
					end else if (cmd_acc && cmd.action == ACT_READ && rp_q < slen_q) begin
						state_q <= S_EMIT_RD;
					end
				end
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CELL_W'(CELLS - 1))
						state_q <= S_INIT;
				end
				S_INIT: begin
					cnt_q        <= '0;
					seq_q        <= '0;
					ng_q         <= '0;
					from_start_q <= 1'b1;
					state_q      <= S_HWAIT;
				end
				S_HWAIT: begin
					if (isq_done) begin
						if (cnt_q == CNT_W'(OPEN_DEPTH)) begin
							stat_q  <= ST_OVERFLOW;
							state_q <= S_EMIT_SR;
						end else begin
							x_q.f   <= f_new;
							x_q.seq <= seq_q;
							x_q.x   <= from_start_q ? sx_q : nx_q;
							x_q.y   <= from_start_q ? sy_q : ny_q;
							hole_q  <= cnt_q[HIDX_W-1:0];
							cnt_q   <= cnt_q + 1'b1;
							seq_q   <= seq_q + 1'b1;
							state_q <= S_PU_RD;
						end
					end
				end
				S_PU_RD: begin
					if (hole_q == '0)
						state_q <= from_start_q ? S_POP : S_NB_NEXT;
					else
						state_q <= S_PU_CMP;
				end
				S_PU_CMP: begin
					if (entry_less(x_q, h_rdata)) begin
						hole_q  <= hp;
						state_q <= S_PU_RD;
					end else begin
						state_q <= from_start_q ? S_POP : S_NB_NEXT;
					end
				end
				S_POP: begin
					if (cnt_q == '0) begin
						stat_q  <= ST_NOPATH;
						state_q <= S_EMIT_SR;
					end else begin
						state_q <= S_PO_TOP;
					end
				end
				S_PO_TOP: begin
					cx_q    <= h_rdata.x;
					cy_q    <= h_rdata.y;
					cnt_q   <= cnt_q - 1'b1;
					state_q <= S_PO_LAST;
				end
				S_PO_LAST: begin
					x_q     <= h_rdata;
					hole_q  <= '0;
					state_q <= (cnt_q == '0) ? S_EXP : S_SD_RL;
				end
				S_SD_RL: begin
					state_q <= l_ok ? S_SD_RR : S_EXP;
				end
				S_SD_RR: begin
					lc_q    <= h_rdata;
					state_q <= S_SD_CMP;
				end
				S_SD_CMP: begin
					if (m_idx == hole_q) begin
						state_q <= S_EXP;
					end else begin
						hole_q  <= m_idx;
						state_q <= S_SD_RL;
					end
				end
				S_EXP: begin
					if (at_goal) begin
						px_q    <= gx_q;
						py_q    <= gy_q;
						len_q   <= LEN_W'(1);
						state_q <= S_PA_CHK;
					end else begin
						state_q <= S_EXP_G;
					end
				end
				S_EXP_G: begin
					g_q     <= cost_rdata;
					dir_q   <= DIR_XP;
					state_q <= S_NB;
				end
				S_NB: begin
					if (nb_in) begin
						nx_q    <= nbx[COORD_W-1:0];
						ny_q    <= nby[COORD_W-1:0];
						state_q <= S_NB_CHK;
					end else begin
						state_q <= S_NB_NEXT;
					end
				end
				S_NB_CHK: begin
					if (upd) begin
						ng_q         <= ng;
						from_start_q <= 1'b0;
						state_q      <= S_HWAIT;
					end else begin
						state_q <= S_NB_NEXT;
					end
				end
				S_NB_NEXT: begin
					if (dir_q == DIR_YN) begin
						state_q <= S_POP;
					end else begin
						dir_q   <= dir_q + 1'b1;
						state_q <= S_NB;
					end
				end
				S_PA_CHK: begin
					if (walk_stop) begin
						px_q    <= gx_q;
						py_q    <= gy_q;
						k_q     <= len_q;
						state_q <= S_PB_WR;
					end else begin
						state_q <= S_PA_STEP;
					end
				end
				S_PA_STEP: begin
					px_q    <= bx;
					py_q    <= by;
					len_q   <= len_q + 1'b1;
					state_q <= S_PA_CHK;
				end
				S_PB_WR: begin
					if (k_q == LEN_W'(1)) begin
						slen_q  <= len_q;
						stat_q  <= ST_FOUND;
						state_q <= S_EMIT_SR;
					end else if (!at_start) begin
						state_q <= S_PB_STEP;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				S_PB_STEP: begin
					px_q    <= bx;
					py_q    <= by;
					k_q     <= k_q - 1'b1;
					state_q <= S_PB_WR;
				end
				S_EMIT_SR: begin
					if (res_take)
						state_q <= S_IDLE;
				end
				S_EMIT_RD: begin
					if (res_take) begin
						rp_q    <= rp_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/grid_astar_path_search_top.sv @@
// Top level of the grid A* path search: configuration registers, engine and output register.
//
//  channel | direction | handshake            | payload
//  cmd     | in        | cmd_valid/cmd_ready  | gas_pkg::cmd_t
//  res     | out       | res_valid/res_ready  | gas_pkg::res_t
//  cfg     | in        | cfg_we               | cfg_index, cfg_data
//
// A load is written in the cycle it is accepted; a read fetches the path cell, then waits on the output register.
// A search first sweeps the cost memory (one entry a cycle), then each heap push or pop
// walks the open-list memory one level at a time, and each push waits for the heuristic
// unit; the memory read ports set the pace.
// Reset starts a sweep that opens every map cell; commands wait until it ends.
// A result waiting in the output register blocks only the next result, not the next command.
module grid_astar_path_search_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_ready,
	input  gas_pkg::cmd_t             cmd,
	output logic                      res_valid,
	input  logic                      res_ready,
	output gas_pkg::res_t             res,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [gas_pkg::DIM_W-1:0] cfg_data
);
	import gas_pkg::*;

	logic [DIM_W-1:0] width_q, height_q;
	logic [DIM_W-1:0] w_clamp, h_clamp;
	eng_res_t         eres;
	logic             res_take;
	res_t             out_q;
	logic             out_valid_q;

	always_comb begin
		w_clamp = (cfg_data == '0) ? DIM_W'(1) : cfg_data;
		h_clamp = w_clamp;
		if (w_clamp > DIM_W'(MAX_WIDTH))
			w_clamp = DIM_W'(MAX_WIDTH);
		if (h_clamp > DIM_W'(MAX_HEIGHT))
			h_clamp = DIM_W'(MAX_HEIGHT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(MAX_WIDTH);
			height_q <= DIM_W'(MAX_HEIGHT);
		end else if (cfg_we) begin
			if (cfg_index == CFG_WIDTH)
				width_q <= w_clamp;
			else if (cfg_index == CFG_HEIGHT)
				height_q <= h_clamp;
		end
	end

	gas_engine u_engine (
		.clk(clk), .arst_n(arst_n), .grid_w(width_q), .grid_h(height_q),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_ready(cmd_ready),
		.eres(eres), .res_take(res_take));

	// advance a finished beat into the output register when it is free or draining
	assign res_take = eres.valid && (!out_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_take)
			out_valid_q <= 1'b1;
		else if (res_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_take)
			out_q <= eres.beat;
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready |-> !eres.valid)
		else $error("engine offers a result while taking commands");

	a_path_found: assert property (@(posedge clk) disable iff (!arst_n)
		eres.valid && eres.beat.result_kind == KIND_PATH |->
			eres.beat.status == ST_FOUND && eres.beat.path_length != '0)
		else $error("path beat without a stored path");

	a_fail_no_len: assert property (@(posedge clk) disable iff (!arst_n)
		eres.valid && eres.beat.result_kind == KIND_REPORT && eres.beat.status != ST_FOUND |->
			eres.beat.path_length == '0)
		else $error("failed search reports a path length");
endmodule

@@ tb/tb_grid_astar_path_search_top.sv @@
// Self-checking testbench of the grid A* path search block: random traffic against a local model.
module tb_grid_astar_path_search_top;
	import gas_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [DIM_W-1:0] cfg_data = '0;

	grid_astar_path_search_top uut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// local copy of the search engine
	int grid_w = 32, grid_h = 32;
	bit blocked[CELLS];
	int cost[CELLS];
	int pdir[CELLS];
	longint heap_f[OPEN_DEPTH];
	int heap_seq[OPEN_DEPTH];
	int heap_cell[OPEN_DEPTH];
	int open_n, seq_n;
	int path_buf[CELLS];
	int path_len, rd_ptr;
	int step_x[4] = '{1, -1, 0, 0};
	int step_y[4] = '{0, 0, 1, -1};

	cmd_t cmd_fifo[$];
	res_t want_res[$];
	int errors = 0;
	bit cmd_fire = 1'b0;
	int burst_left = 0, gap_left = 0;
	int stall_mode = 0, stall_cnt = 0;

	function automatic longint root_floor(longint v);
		longint r, b;
		r = 0;
		for (b = 1 << 16; b > 0; b >>= 1)
			if ((r + b) * (r + b) <= v) r += b;
		return r;
	endfunction

	function automatic longint heur_dist(int x, int y, int gx, int gy);
		longint dx, dy;
		dx = x > gx ? x - gx : gx - x;
		dy = y > gy ? y - gy : gy - y;
		return root_floor((dx * dx + dy * dy) << (2 * HEUR_FRAC_BITS));
	endfunction

	function automatic bit heap_less(int a, int b);
		if (heap_f[a] != heap_f[b]) return heap_f[a] < heap_f[b];
		return heap_seq[a] < heap_seq[b];
	endfunction

	function automatic void heap_swap(int a, int b);
		longint tf;
		int ts, tc;
		tf = heap_f[a]; heap_f[a] = heap_f[b]; heap_f[b] = tf;
		ts = heap_seq[a]; heap_seq[a] = heap_seq[b]; heap_seq[b] = ts;
		tc = heap_cell[a]; heap_cell[a] = heap_cell[b]; heap_cell[b] = tc;
	endfunction

	function automatic bit open_push(longint f, int c);
		int i, p;
		if (open_n >= OPEN_DEPTH) return 1'b0;
		i = open_n++;
		heap_f[i] = f;
		heap_seq[i] = seq_n++;
		heap_cell[i] = c;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!heap_less(i, p)) break;
			heap_swap(i, p);
			i = p;
		end
		return 1'b1;
	endfunction

	function automatic int open_pop();
		int c, i, l, r, m;
		c = heap_cell[0];
		i = 0;
		open_n--;
		heap_f[0] = heap_f[open_n];
		heap_seq[0] = heap_seq[open_n];
		heap_cell[0] = heap_cell[open_n];
		forever begin
			l = 2 * i + 1;
			r = l + 1;
			m = i;
			if (l < open_n && heap_less(l, m)) m = l;
			if (r < open_n && heap_less(r, m)) m = r;
			if (m == i) break;
			heap_swap(i, m);
			i = m;
		end
		return c;
	endfunction

	function automatic int parent_of(int c);
		return c - step_x[pdir[c]] - step_y[pdir[c]] * grid_w;
	endfunction

	function automatic logic [1:0] astar_search(int sx, int sy, int gx, int gy);
		int w, h, sc, gc, cur, g, nx, ny, nc, len, c, d, k;
		w = grid_w;
		h = grid_h;
		path_len = 0;
		rd_ptr = 0;
		if (sx >= w || sy >= h || gx >= w || gy >= h) return ST_BADXY;
		for (int i = 0; i < CELLS; i++) cost[i] = 2047;
		open_n = 0;
		seq_n = 0;
		sc = sy * w + sx;
		gc = gy * w + gx;
		cost[sc] = 0;
		if (!open_push(heur_dist(sx, sy, gx, gy), sc)) return ST_OVERFLOW;
		while (open_n > 0) begin
			cur = open_pop();
			g = cost[cur];
			if (cur == gc) begin
				len = 1;
				c = gc;
				while (c != sc && len < CELLS) begin
					c = parent_of(c);
					len++;
				end
				c = gc;
				for (k = len; k > 0; k--) begin
					path_buf[k - 1] = c;
					if (c != sc) c = parent_of(c);
				end
				path_len = len;
				return ST_FOUND;
			end
			for (d = 0; d < 4; d++) begin
				nx = cur % w + step_x[d];
				ny = cur / w + step_y[d];
				if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
				nc = ny * w + nx;
				if (blocked[nc]) continue;
				if (g + 1 < cost[nc]) begin
					cost[nc] = g + 1;
					pdir[nc] = d;
					if (!open_push((longint'(g + 1) << HEUR_FRAC_BITS) +
						heur_dist(nx, ny, gx, gy), nc))
						return ST_OVERFLOW;
				end
			end
		end
		return ST_NOPATH;
	endfunction

	// predict one command's result and queue it for the driver
	task automatic queue_cmd(logic [1:0] act, int idx, bit blk, int sx, int sy, int gx, int gy);
		cmd_t c;
		res_t r;
		c.action = act;
		c.cell_index = 10'(idx);
		c.cell_blocked = blk;
		c.start_x = 5'(sx);
		c.start_y = 5'(sy);
		c.goal_x = 5'(gx);
		c.goal_y = 5'(gy);
		r = '0;
		if (act == ACT_LOAD) begin
			blocked[c.cell_index] = blk;
		end else if (act == ACT_SEARCH) begin
			r.result_kind = KIND_REPORT;
			r.status = astar_search(c.start_x, c.start_y, c.goal_x, c.goal_y);
			r.path_length = 11'(path_len);
			want_res = {want_res, r};
		end else if (act == ACT_READ && rd_ptr < path_len) begin
			r.result_kind = KIND_PATH;
			r.path_length = 11'(path_len);
			r.path_cell = 10'(path_buf[rd_ptr]);
			r.last = (rd_ptr + 1 == path_len);
			rd_ptr++;
			want_res = {want_res, r};
		end
		cmd_fifo = {cmd_fifo, c};
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (cmd_fifo.size() != 0 || cmd_valid || want_res.size() != 0);
		// a trailing load or empty read may still be in flight
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int v);
		int m;
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = DIM_W'(v);
		@(negedge clk);
		cfg_we = 1'b0;
		m = v & 63;
		if (m == 0) m = 1;
		if (idx == CFG_WIDTH) grid_w = m > MAX_WIDTH ? MAX_WIDTH : m;
		else grid_h = m > MAX_HEIGHT ? MAX_HEIGHT : m;
	endtask

	task automatic run_search_rand(int oob_pct);
		int sx, sy, gx, gy;
		sx = $urandom_range(0, grid_w - 1);
		sy = $urandom_range(0, grid_h - 1);
		gx = $urandom_range(0, grid_w - 1);
		gy = $urandom_range(0, grid_h - 1);
		if ($urandom_range(0, 99) < oob_pct) begin
			case ($urandom_range(0, 3))
				0: sx = $urandom_range(0, 31);
				1: sy = $urandom_range(0, 31);
				2: gx = $urandom_range(0, 31);
				default: gy = $urandom_range(0, 31);
			endcase
		end
		queue_cmd(ACT_SEARCH, 0, 0, sx, sy, gx, gy);
	endtask

	// driver: new beat at the falling edge once the previous one is taken
	always @(negedge clk) begin
		if (arst_n && (!cmd_valid || cmd_fire)) begin
			if (gap_left > 0) begin
				gap_left--;
				cmd_valid <= 1'b0;
			end else if (cmd_fifo.size() != 0) begin
				cmd <= cmd_fifo.pop_front();
				cmd_valid <= 1'b1;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 30);
					gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern: ready, coin flip, or long stalls, switching now and then
	always @(negedge clk) begin
		if (stall_cnt == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_cnt = $urandom_range(20, 200);
		end else begin
			stall_cnt--;
		end
		case (stall_mode)
			0: res_ready <= 1'b1;
			1: res_ready <= 1'($urandom_range(0, 1));
			default: res_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		res_t e;
		cmd_fire <= cmd_valid && cmd_ready;
		if (arst_n && res_valid && res_ready) begin
			if (want_res.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, res);
				errors++;
			end else begin
				e = want_res.pop_front();
				if (res.result_kind !== e.result_kind || res.status !== e.status ||
					res.path_length !== e.path_length || res.path_cell !== e.path_cell ||
					res.last !== e.last) begin
					$display("%0t: mismatch, expected %p, actual %p", $time, e, res);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (200) #50_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int sent, big, n, reads, idx;
		int density;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset size, extremes of the fields
		queue_cmd(ACT_LOAD, 1023, 1, 0, 0, 0, 0);
		queue_cmd(ACT_LOAD, 1023, 0, 0, 0, 0, 0);
		queue_cmd(ACT_SEARCH, 0, 0, 0, 0, 0, 0);
		queue_cmd(ACT_READ, 0, 0, 0, 0, 0, 0);
		queue_cmd(ACT_READ, 0, 0, 0, 0, 0, 0);
		queue_cmd(2'd3, 1023, 1, 31, 31, 31, 31);
		queue_cmd(ACT_SEARCH, 0, 0, 31, 31, 31, 0);
		repeat (3) queue_cmd(ACT_READ, 0, 0, 0, 0, 0, 0);
		wait_idle();
		// zero and oversized register values clamp
		write_reg(CFG_WIDTH, 0);
		write_reg(CFG_HEIGHT, 63);
		queue_cmd(ACT_SEARCH, 0, 0, 0, 0, 0, 31);
		queue_cmd(ACT_READ, 0, 0, 0, 0, 0, 0);
		queue_cmd(ACT_SEARCH, 0, 0, 1, 0, 0, 5);
		queue_cmd(ACT_READ, 0, 0, 0, 0, 0, 0);
		wait_idle();
		// wall down column one: no path across it, but one down column zero
		write_reg(CFG_WIDTH, 4);
		write_reg(CFG_HEIGHT, 3);
		queue_cmd(ACT_LOAD, 1, 1, 0, 0, 0, 0);
		queue_cmd(ACT_LOAD, 5, 1, 0, 0, 0, 0);
		queue_cmd(ACT_LOAD, 9, 1, 0, 0, 0, 0);
		queue_cmd(ACT_SEARCH, 0, 0, 0, 0, 3, 2);
		queue_cmd(ACT_READ, 0, 0, 0, 0, 0, 0);
		queue_cmd(ACT_SEARCH, 0, 0, 0, 0, 0, 2);
		queue_cmd(ACT_READ, 0, 0, 0, 0, 0, 0);

		sent = 0;
		big = 0;
		while (sent < 1800) begin
			wait_idle();
			if (big < 3 && $urandom_range(0, 9) == 0) begin
				write_reg(CFG_WIDTH, 32);
				write_reg(CFG_HEIGHT, 32);
				big++;
			end else if ($urandom_range(0, 7) == 0) begin
				write_reg(CFG_WIDTH, $urandom_range(0, 1) ? 1 : $urandom_range(33, 63));
				write_reg(CFG_HEIGHT, $urandom_range(1, 6));
			end else begin
				write_reg(CFG_WIDTH, $urandom_range(1, 10));
				write_reg(CFG_HEIGHT, $urandom_range(1, 10));
			end
			density = $urandom_range(0, 40);
			n = $urandom_range(60, 150);
			for (int k = 0; k < n; k++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: begin
						if ($urandom_range(0, 19) == 0) idx = $urandom_range(0, 1023);
						else idx = $urandom_range(0, grid_w * grid_h - 1);
						queue_cmd(ACT_LOAD, idx, $urandom_range(0, 99) < density,
							$urandom_range(0, 31), $urandom_range(0, 31),
							$urandom_range(0, 31), $urandom_range(0, 31));
						sent++;
					end
					5, 6, 7: begin
						run_search_rand(10);
						reads = path_len - ($urandom_range(0, 4) == 0 ?
							$urandom_range(0, path_len) : 0) + $urandom_range(0, 2);
						sent += 1 + reads;
						k += reads;
						repeat (reads) queue_cmd(ACT_READ, 0, 0, 0, 0, 0, 0);
					end
					8: begin
						queue_cmd(ACT_READ, 0, 0, 0, 0, 0, 0);
						sent++;
					end
					default: queue_cmd(2'd3, $urandom_range(0, 1023), $urandom_range(0, 1),
						$urandom_range(0, 31), $urandom_range(0, 31),
						$urandom_range(0, 31), $urandom_range(0, 31));
				endcase
				// hold off the sender until the block drains
				if ((sent < 200 || $urandom_range(0, 99) == 0) && k == n / 2) wait_idle();
			end
		end

		wait_idle();
		repeat (200) @(posedge clk);
		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

endmodule

@@ grid_astar_path_search_top.f @@
rtl/gas_pkg.sv
rtl/gas_ram.sv
rtl/gas_isqrt.sv
rtl/gas_engine.sv
rtl/grid_astar_path_search_top.sv
tb/tb_grid_astar_path_search_top.sv
